FILE: hdl/positional_list_insert_delete_defines.svh
// Assertion macros for the positional list block.
// No dependencies; included by modules that carry concurrent checks.
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PLI_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PLI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/pli_pkg.sv
// Shared types and constants for the positional list block.
// No dependencies; used by pli_cell and positional_list_insert_delete.
package pli_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned POS_W   = 6;
   localparam int unsigned COUNT_W = 6;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } opcode_type;

   typedef logic [WORD_W-1:0] word_type;

   // Broadcast to every cell; enables are already qualified by accept and check.
   typedef struct packed {
      logic     ins_en;
      logic     del_en;
      word_type ins_value;
   } cell_ctrl_type;

endpackage

FILE: hdl/positional_list_insert_delete.sv
// Positional list: a row of pli_cell slots plus length counter and response register.
// Depends on pli_pkg, pli_cell and positional_list_insert_delete_defines.svh.
//
//  channel | signals                                          | direction
//  req     | req_valid/ready, opcode, position, new_value     | in
//  rsp     | rsp_valid/ready, status, read_value, count_after | out
//
// For each request every cell compares its slot index with the position and
// shifts in parallel, and the response is registered.
// A new request is taken while the held response is being taken (one stage).
// Reset clears the length and the response valid; slot contents are not reset.
// A stalled response holds req_ready low until rsp_ready returns.
`include "positional_list_insert_delete_defines.svh"

module positional_list_insert_delete
   import pli_pkg::*;
#(
   parameter int unsigned CAPACITY = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_opcode,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [WORD_W-1:0]  req_new_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_status,
   output logic signed [WORD_W-1:0]  rsp_read_value,
   output logic [COUNT_W-1:0]        rsp_count_after
);

   localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
   localparam int unsigned CW    = ($clog2(CAPACITY + 2) > POS_W) ?
                                   $clog2(CAPACITY + 2) : POS_W;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [LEN_W-1:0]   len_ff;
   logic [LEN_W-1:0]   len_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_status_ff;
   logic               rsp_status_in;
   word_type           rsp_value_ff;
   word_type           rsp_value_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [COUNT_W-1:0] rsp_count_in;

   logic               accept;
   logic               ok;
   logic [CW-1:0]      pos_w;
   logic [CW-1:0]      len_w;
   logic [CW-1:0]      pos_idx;
   word_type           rd_any;
   cell_ctrl_type      ctrl;

   word_type cell_value [CAPACITY];
   word_type cell_rd    [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign pos_w     = CW'(req_position);
   assign len_w     = CW'(len_ff);
   assign pos_idx   = pos_w - CW'(1);

   always_comb begin
      ok = 1'b0;
      case (req_opcode)
         OP_READ, OP_DELETE: ok = (pos_w != '0) && (pos_w <= len_w);
         OP_INSERT:          ok = (pos_w != '0) && (pos_w <= len_w + CW'(1)) &&
                                  (len_w < CAP_C);
         default:            ok = 1'b0;
      endcase
   end

   always_comb begin
      ctrl.ins_en    = accept && ok && (req_opcode == OP_INSERT);
      ctrl.del_en    = accept && ok && (req_opcode == OP_DELETE);
      ctrl.ins_value = word_type'(req_new_value);
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      word_type left_v;
      word_type right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_value[i+1];
      end
      pli_cell #(
         .IDX_W (CW),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .pos_idx     (pos_idx),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (cell_value[i]),
         .rd_value    (cell_rd[i])
      );
   end

   // At most one cell matches, so an OR picks the addressed slot.
   always_comb begin
      rd_any = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_any = rd_any | cell_rd[i];
      end
   end

   always_comb begin
      len_in        = len_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      if (accept) begin
         if (ctrl.ins_en) begin
            len_in = len_ff + LEN_W'(1);
         end else if (ctrl.del_en) begin
            len_in = len_ff - LEN_W'(1);
         end
         rsp_valid_in  = 1'b1;
         rsp_status_in = !ok;
         rsp_value_in  = (ok && (req_opcode != OP_INSERT)) ? rd_any : '0;
         rsp_count_in  = COUNT_W'(len_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_count_after = rsp_count_ff;

   `PLI_ASSERT_SAME(a_len_bound, clock, reset, 1'b1, CW'(len_ff) <= CAP_C, "length above capacity")
   `PLI_ASSERT_NEXT(a_ins_grows, clock, reset, ctrl.ins_en, len_ff == $past(len_ff) + LEN_W'(1), "insert did not grow list")
   `PLI_ASSERT_NEXT(a_reject_keeps, clock, reset, accept && !ok, $stable(len_ff), "rejected request changed length")
   `PLI_ASSERT_NEXT(a_count_match, clock, reset, accept, rsp_valid && (rsp_count_after == COUNT_W'(len_ff)), "count_after differs from length")

endmodule

FILE: hdl/pli_cell.sv
// One slot of the list: holds a word, shifts from its neighbors on insert/delete.
// Depends on pli_pkg.
module pli_cell
   import pli_pkg::*;
#(
   parameter int unsigned IDX_W = 6,
   parameter int unsigned INDEX = 0
) (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [IDX_W-1:0]  pos_idx,
   input  word_type          left_value,
   input  word_type          right_value,
   output word_type          value,
   output word_type          rd_value
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   word_type entry_ff;
   word_type entry_in;
   logic     hit;
   logic     above;

   assign hit   = (pos_idx == MY_IDX);
   assign above = (pos_idx < MY_IDX);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en) begin
         if (above) begin
            entry_in = left_value;
         end else if (hit) begin
            entry_in = ctrl.ins_value;
         end
      end else if (ctrl.del_en) begin
         if (above || hit) begin
            entry_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign value    = entry_ff;
   assign rd_value = hit ? entry_ff : '0;

endmodule

FILE: tb/tb_positional_list_insert_delete.sv
// Self-checking testbench for positional_list_insert_delete: directed table, then random
// fill/drain/mix rounds with idling on both channels. Depends on pli_pkg and the block RTL.
module tb_positional_list_insert_delete
   import pli_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LIST_CAP    = 32;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          ROUNDS      = 8;
   localparam logic [1:0]  OP_UNUSED   = 2'd3;

   typedef struct packed {
      logic               status;
      logic [WORD_W-1:0]  value;
      logic [COUNT_W-1:0] count;
   } outcome_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] val;
      logic              typed;
      outcome_type       want;
   } dir_row_type;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_mode_type;

   // Expected outcome is typed in only where it is obvious; other rows use the predictor.
   localparam int DIR_ROWS = 23;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{OP_READ,   6'd1,  32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 6'd0}},
      '{OP_DELETE, 6'd1,  32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 6'd0}},
      '{OP_INSERT, 6'd0,  32'h0000_0005, 1'b1, '{1'b1, 32'h0000_0000, 6'd0}},
      '{OP_INSERT, 6'd2,  32'h0000_0006, 1'b1, '{1'b1, 32'h0000_0000, 6'd0}},
      '{OP_UNUSED, 6'd1,  32'h0000_0009, 1'b1, '{1'b1, 32'h0000_0000, 6'd0}},
      '{OP_INSERT, 6'd1,  32'h7fff_ffff, 1'b1, '{1'b0, 32'h0000_0000, 6'd1}},
      '{OP_INSERT, 6'd1,  32'h8000_0000, 1'b1, '{1'b0, 32'h0000_0000, 6'd2}},
      '{OP_INSERT, 6'd3,  32'hffff_ffff, 1'b1, '{1'b0, 32'h0000_0000, 6'd3}},
      '{OP_READ,   6'd1,  32'h0000_0000, 1'b1, '{1'b0, 32'h8000_0000, 6'd3}},
      '{OP_READ,   6'd3,  32'h0000_0000, 1'b1, '{1'b0, 32'hffff_ffff, 6'd3}},
      '{OP_READ,   6'd4,  32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 6'd3}},
      '{OP_INSERT, 6'd5,  32'h1234_5678, 1'b1, '{1'b1, 32'h0000_0000, 6'd3}},
      '{OP_READ,   6'd63, 32'hffff_ffff, 1'b1, '{1'b1, 32'h0000_0000, 6'd3}},
      '{OP_DELETE, 6'd0,  32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 6'd3}},
      '{OP_DELETE, 6'd4,  32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 6'd3}},
      '{OP_INSERT, 6'd2,  32'h0000_0001, 1'b0, '0},
      '{OP_INSERT, 6'd4,  32'ha5a5_a5a5, 1'b0, '0},
      '{OP_DELETE, 6'd2,  32'h0000_0000, 1'b0, '0},
      '{OP_READ,   6'd2,  32'h0000_0000, 1'b0, '0},
      '{OP_DELETE, 6'd4,  32'h0000_0000, 1'b0, '0},
      '{OP_DELETE, 6'd1,  32'h0000_0000, 1'b0, '0},
      '{OP_UNUSED, 6'd2,  32'hffff_ffff, 1'b1, '{1'b1, 32'h0000_0000, 6'd2}},
      '{OP_READ,   6'd2,  32'h0000_0000, 1'b0, '0}
   };

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [1:0]               req_opcode;
   logic [POS_W-1:0]         req_position;
   logic signed [WORD_W-1:0] req_new_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic                     rsp_status;
   logic signed [WORD_W-1:0] rsp_read_value;
   logic [COUNT_W-1:0]       rsp_count_after;

   // predictor state
   logic [WORD_W-1:0] list_words [LIST_CAP];
   int                list_len;

   outcome_type pending_responses[$];
   int          error_count;
   int          cycle_count;
   bit          sender_idles;
   bit          sink_stalls;

   positional_list_insert_delete #(
      .CAPACITY (LIST_CAP)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .req_new_value   (req_new_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_count_after (rsp_count_after)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic outcome_type predict_list_op(input logic [1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [WORD_W-1:0] val);
      outcome_type res;
      int          p;
      int          k;
      res = '{1'b1, '0, '0};
      p   = int'(pos);
      case (op)
         OP_READ: begin
            if (p >= 1 && p <= list_len) begin
               res.value  = list_words[p-1];
               res.status = 1'b0;
            end
         end
         OP_INSERT: begin
            if (p >= 1 && p <= list_len + 1 && list_len < LIST_CAP) begin
               for (k = list_len; k > p - 1; k--) list_words[k] = list_words[k-1];
               list_words[p-1] = val;
               list_len++;
               res.status = 1'b0;
            end
         end
         OP_DELETE: begin
            if (p >= 1 && p <= list_len) begin
               res.value = list_words[p-1];
               for (k = p; k < list_len; k++) list_words[k-1] = list_words[k];
               list_len--;
               res.status = 1'b0;
            end
         end
         default: ;
      endcase
      res.count = list_len[COUNT_W-1:0];
      return res;
   endfunction

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(input logic [1:0] op, input logic [POS_W-1:0] pos,
                               input logic [WORD_W-1:0] val, input logic typed,
                               input outcome_type want);
      outcome_type res;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_position  <= pos;
      req_new_value <= val;
      do @(posedge clock); while (!req_ready);
      res = predict_list_op(op, pos, val);
      pending_responses.push_back(typed ? want : res);
      @(negedge clock);
   endtask

   task automatic wait_list_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_responses.size() != 0) @(negedge clock);
   endtask

   task automatic random_request(input mix_mode_type mode);
      logic [1:0]        op;
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] val;
      int                r;
      int                top;
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_UNUSED;
      else if (mode == MODE_FILL) op = (r < 68) ? OP_INSERT : (r < 84) ? OP_READ : OP_DELETE;
      else if (mode == MODE_DRAIN) op = (r < 68) ? OP_DELETE : (r < 84) ? OP_READ : OP_INSERT;
      else op = (r < 35) ? OP_INSERT : (r < 68) ? OP_DELETE : OP_READ;

      r = $urandom_range(0, 99);
      if (r < 80) begin
         top = (op == OP_INSERT) ? list_len + 1 : list_len;
         if (top < 1) top = 1;
         pos = POS_W'($urandom_range(1, top));
      end else if (r < 88) begin
         case ($urandom_range(0, 4))
            0:       pos = '0;
            1:       pos = POS_W'(list_len);
            2:       pos = POS_W'(list_len + 1);
            3:       pos = POS_W'(LIST_CAP);
            default: pos = POS_W'(LIST_CAP + 1);
         endcase
      end else begin
         pos = POS_W'($urandom_range(0, 63));
      end

      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7fff_ffff;
            2:       val = 32'h0000_0000;
            default: val = 32'hffff_ffff;
         endcase
      end else begin
         val = $urandom;
      end
      send_request(op, pos, val, 1'b0, '0);
   endtask

   always @(posedge clock) begin : rsp_check
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_read_value !== want.value) begin
               $error("read_value: expected %h, got %h", want.value, rsp_read_value);
               error_count++;
            end
            if (rsp_count_after !== want.count) begin
               $error("count_after: expected %0d, got %0d", want.count, rsp_count_after);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // response side back-pressure
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (sink_stalls && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = '0;
      req_position  = '0;
      req_new_value = '0;
      error_count   = 0;
      cycle_count   = 0;
      list_len      = 0;
      sender_idles  = 1'b1;
      sink_stalls   = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_request(DIRECTED[i].op, DIRECTED[i].pos, DIRECTED[i].val,
                      DIRECTED[i].typed, DIRECTED[i].want);
      end
      wait_list_idle();

      for (int rnd = 0; rnd < ROUNDS; rnd++) begin
         // odd rounds run the sender flat out; the last round has no idling at all
         sender_idles = (rnd % 2 == 0) && (rnd != ROUNDS - 1);
         sink_stalls  = (rnd != ROUNDS - 1) && (rnd != 3);
         for (int n = 0; n < 85; n++) random_request(MODE_FILL);
         for (int n = 0; n < 85; n++) random_request(MODE_DRAIN);
         for (int n = 0; n < 35; n++) random_request(MODE_MIX);
         wait_list_idle();
      end

      repeat (8) @(negedge clock);
      if (error_count == 0 && pending_responses.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
